FILE: rtl/gra_pkg.sv
// Package for the grid rectangle allocator.
// Command and status codes. No dependencies.
package gra_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic ST_OK     = 1'b0;
    localparam logic ST_FAIL   = 1'b1;

endpackage

FILE: rtl/gra_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

FILE: rtl/grid_rectangle_allocator.sv
// Grid rectangle allocator: first-fit alloc and free of rectangles on a cell grid.
// Depends on gra_pkg and gra_ram (cell map memory).
//
// channel | dir | handshake                  | fields
// in      | in  | i_in_valid / o_in_stall    | i_cmd i_rect_w i_rect_h i_pos_x i_pos_y
// out     | out | o_out_valid / i_out_stall  | o_status o_place_x o_place_y
//
// One item at a time; every cell access goes through the cell map memory.
// Alloc: a scan of up to GRID_W*GRID_H cells, the w*h fill, then a recount
// up each column of the rectangle. Free: left/up/down/right marches one
// cell a cycle, the fill, then the recount. Then the result is posted.
// After reset a clearing pass over every cell loads the map; o_in_stall
// stays high until it ends. A result waits in the output register under stall.
module grid_rectangle_allocator #(
    parameter int GRID_W = 32,
    parameter int GRID_H = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd,
    input  logic [5:0] i_rect_w,
    input  logic [5:0] i_rect_h,
    input  logic [4:0] i_pos_x,
    input  logic [4:0] i_pos_y,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_status,
    output logic [4:0] o_place_x,
    output logic [4:0] o_place_y
);

    localparam int XW = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int YW = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int DEPTH = GRID_W * GRID_H;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(GRID_H + 1) + 1;
    localparam int RW = $clog2(GRID_W + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_CHK, S_LEFT, S_UP, S_DN0, S_DN,
        S_RT0, S_RT, S_SET, S_FILL, S_RCOL, S_RUP, S_OUT
    } t_state;

    t_state               r_state, n_state;
    logic [XW-1:0]        r_ax, n_ax, r_wx, n_wx, r_x0, n_x0, r_x1, n_x1;
    logic [YW-1:0]        r_ay, n_ay, r_wy, n_wy, r_y0, n_y0, r_y1, n_y1;
    logic [YW:0]          r_ybot, n_ybot;
    logic                 r_mark, n_mark;
    logic [5:0]           r_w, n_w, r_h, n_h;
    logic [RW-1:0]        r_run, n_run, run_n;
    logic signed [CW-1:0] r_v, n_v, r_below, n_below;
    logic                 r_pst, n_pst;
    logic [4:0]           r_px, n_px, r_py, n_py;
    logic                 r_ov, n_ov, r_ost, n_ost;
    logic [4:0]           r_opx, n_opx, r_opy, n_opy;
    logic                 r_fh;
    logic signed [CW-1:0] r_fd;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic signed [CW-1:0] wdata, ram_q, cur, dy;
    logic signed [15:0]   cur16, h16;
    logic                 acc;
    logic [XW-1:0]        tx;
    logic [YW-1:0]        ybot_c, y1_c;

    function automatic logic [AW-1:0] f_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
        f_addr = AW'(32'(y) * GRID_W + 32'(x));
    endfunction

    gra_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    assign cur        = r_fh ? r_fd : ram_q;
    assign cur16      = 16'(cur);
    assign h16        = signed'({10'd0, r_h});
    assign o_in_stall = (r_state != S_IDLE);
    assign acc        = i_in_valid && !o_in_stall;
    assign run_n      = (cur16 >= h16) ? RW'(r_run + 1'b1) : '0;
    assign tx         = XW'(32'(r_ax) + 1 - 32'(r_w));
    assign ybot_c     = (32'(r_ybot) >= GRID_H) ? YW'(GRID_H - 1) : YW'(r_ybot);
    assign y1_c       = (32'(r_ay) + 32'(r_h) - 1 >= GRID_H) ? YW'(GRID_H - 1)
                                                           : YW'(32'(r_ay) + 32'(r_h) - 1);
    assign dy         = CW'(32'(r_wy) - 32'(r_y0) + 1);
    assign raddr      = f_addr(n_ax, n_ay);

    always_comb begin
        we    = 1'b0;
        waddr = f_addr(r_wx, r_wy);
        wdata = '0;
        case (r_state)
            S_INIT: begin
                we    = 1'b1;
                wdata = CW'(32'(GRID_H) - 32'(r_wy));
            end
            S_FILL: begin
                we = 1'b1;
                if (!r_mark) begin
                    wdata = CW'(1);
                end else if (r_wx == r_x0) begin
                    wdata = CW'(0) - dy;
                end
            end
            S_RUP: begin
                waddr = f_addr(r_ax, r_ay);
                if (cur > 0) begin
                    we    = 1'b1;
                    wdata = r_below + CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_ax = r_ax;  n_ay = r_ay;  n_wx = r_wx;  n_wy = r_wy;
        n_x0 = r_x0;  n_x1 = r_x1;  n_y0 = r_y0;  n_y1 = r_y1;
        n_ybot = r_ybot;  n_mark = r_mark;  n_w = r_w;  n_h = r_h;
        n_run = r_run;  n_v = r_v;  n_below = r_below;
        n_pst = r_pst;  n_px = r_px;  n_py = r_py;
        n_ov = r_ov;  n_ost = r_ost;  n_opx = r_opx;  n_opy = r_opy;
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_INIT: begin
                if (32'(r_wx) == GRID_W - 1) begin
                    n_wx = '0;
                    if (32'(r_wy) == GRID_H - 1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_wy = r_wy + 1'b1;
                    end
                end else begin
                    n_wx = r_wx + 1'b1;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_pst = gra_pkg::ST_FAIL;
                    n_px  = '0;
                    n_py  = '0;
                    n_w   = i_rect_w;
                    n_h   = i_rect_h;
                    if (i_cmd == gra_pkg::CMD_ALLOC) begin
                        if (i_rect_w == '0 || i_rect_h == '0 || 32'(i_rect_w) > GRID_W) begin
                            n_state = S_OUT;
                        end else begin
                            n_ax    = '0;
                            n_ay    = '0;
                            n_run   = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (32'(i_pos_x) >= GRID_W || 32'(i_pos_y) >= GRID_H) begin
                            n_state = S_OUT;
                        end else begin
                            n_ax    = XW'(i_pos_x);
                            n_ay    = YW'(i_pos_y);
                            n_state = S_CHK;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (32'(run_n) == 32'(r_w)) begin
                    n_x0    = tx;
                    n_x1    = XW'(32'(tx) + 32'(r_w) - 1);
                    n_y0    = r_ay;
                    n_y1    = y1_c;
                    n_ybot  = (YW+1)'(r_ay);
                    n_mark  = 1'b1;
                    n_wx    = tx;
                    n_wy    = r_ay;
                    n_pst   = gra_pkg::ST_OK;
                    n_px    = 5'(tx);
                    n_py    = 5'(r_ay);
                    n_state = S_FILL;
                end else if (32'(r_ax) == GRID_W - 1) begin
                    if (32'(r_ay) == GRID_H - 1) begin
                        n_state = S_OUT;
                    end else begin
                        n_ax  = '0;
                        n_ay  = r_ay + 1'b1;
                        n_run = '0;
                    end
                end else begin
                    n_ax  = r_ax + 1'b1;
                    n_run = run_n;
                end
            end
            S_CHK, S_LEFT: begin
                if (r_state == S_CHK && cur > 0) begin
                    n_state = S_OUT;
                end else if (r_ax != '0 && cur == 0) begin
                    n_ax    = r_ax - 1'b1;
                    n_state = S_LEFT;
                end else begin
                    n_v  = cur;
                    n_x0 = r_ax;
                    n_y1 = r_ay;
                    if (r_ay == '0) begin
                        n_state = S_DN0;
                    end else begin
                        n_ay    = r_ay - 1'b1;
                        n_state = S_UP;
                    end
                end
            end
            S_UP: begin
                if (r_v < cur && cur < 0) begin
                    n_v  = cur;
                    n_y1 = r_ay;
                    if (r_ay == '0) begin
                        n_state = S_DN0;
                    end else begin
                        n_ay = r_ay - 1'b1;
                    end
                end else begin
                    n_state = S_DN0;
                end
            end
            S_DN0: begin
                n_y0 = r_y1;
                n_ax = r_x0;
                if (32'(r_y1) + 1 >= GRID_H) begin
                    n_state = S_RT0;
                end else begin
                    n_ay    = r_y1 + 1'b1;
                    n_state = S_DN;
                end
            end
            S_DN: begin
                if (r_v > cur) begin
                    n_v  = cur;
                    n_y1 = r_ay;
                    if (32'(r_ay) + 1 >= GRID_H) begin
                        n_state = S_RT0;
                    end else begin
                        n_ay = r_ay + 1'b1;
                    end
                end else begin
                    n_state = S_RT0;
                end
            end
            S_RT0: begin
                n_x1 = r_x0;
                if (32'(r_x0) + 1 >= GRID_W) begin
                    n_state = S_SET;
                end else begin
                    n_ax    = r_x0 + 1'b1;
                    n_ay    = r_y1;
                    n_state = S_RT;
                end
            end
            S_RT: begin
                if (cur == 0) begin
                    n_x1 = r_ax;
                    if (32'(r_ax) + 1 >= GRID_W) begin
                        n_state = S_SET;
                    end else begin
                        n_ax = r_ax + 1'b1;
                    end
                end else begin
                    n_state = S_SET;
                end
            end
            S_SET: begin
                n_ybot  = (YW+1)'(32'(r_y1) + 1);
                n_mark  = 1'b0;
                n_wx    = r_x0;
                n_wy    = r_y0;
                n_pst   = gra_pkg::ST_OK;
                n_state = S_FILL;
            end
            S_FILL: begin
                if (r_wx == r_x1) begin
                    n_wx = r_x0;
                    if (r_wy == r_y1) begin
                        if (r_ybot == '0) begin
                            n_state = S_OUT;
                        end else begin
                            n_ax    = r_x0;
                            n_ay    = ybot_c;
                            n_state = S_RCOL;
                        end
                    end else begin
                        n_wy = r_wy + 1'b1;
                    end
                end else begin
                    n_wx = r_wx + 1'b1;
                end
            end
            S_RCOL: begin
                n_below = (32'(r_ybot) < GRID_H && cur > 0) ? cur : '0;
                n_ay    = YW'(r_ybot - 1'b1);
                n_state = S_RUP;
            end
            S_RUP: begin
                if (cur > 0 && r_ay != '0) begin
                    n_below = r_below + CW'(1);
                    n_ay    = r_ay - 1'b1;
                end else if (r_ax == r_x1) begin
                    n_state = S_OUT;
                end else begin
                    n_ax    = r_ax + 1'b1;
                    n_ay    = ybot_c;
                    n_state = S_RCOL;
                end
            end
            S_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_ost   = r_pst;
                    n_opx   = r_px;
                    n_opy   = r_py;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_wx    <= '0;
            r_wy    <= '0;
            r_ov    <= 1'b0;
            r_fh    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wx    <= n_wx;
            r_wy    <= n_wy;
            r_ov    <= n_ov;
            r_fh    <= we && (waddr == raddr);
        end
        r_fd   <= wdata;
        r_ax   <= n_ax;   r_ay <= n_ay;
        r_x0   <= n_x0;   r_x1 <= n_x1;   r_y0 <= n_y0;   r_y1 <= n_y1;
        r_ybot <= n_ybot; r_mark <= n_mark;
        r_w    <= n_w;    r_h <= n_h;     r_run <= n_run;
        r_v    <= n_v;    r_below <= n_below;
        r_pst  <= n_pst;  r_px <= n_px;   r_py <= n_py;
        r_ost  <= n_ost;  r_opx <= n_opx; r_opy <= n_opy;
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_ost;
    assign o_place_x   = r_opx;
    assign o_place_y   = r_opy;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !we)
        else $error("cell map written while idle");

    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |->
            (r_wx >= r_x0 && r_wx <= r_x1 && r_wy >= r_y0 && r_wy <= r_y1))
        else $error("fill outside rectangle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_state != S_IDLE && r_state != S_INIT))
        else $error("accepted item not started");

endmodule
